/* design/assert_macros.svh */
// Assertion macros used by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define CHK_CLK(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Implication check on the rising clock.
`define CHK_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	`CHK_CLK(lbl, clk_s, rst_n_s, (ante) |-> (cons), msg)

`endif

/* design/tnsc_pkg.sv */
// Types and constants of the triangle shade and cull core.
package tnsc_pkg;

	typedef enum logic [1:0] {
		REG_BASE_RED   = 2'd0,
		REG_BASE_GREEN = 2'd1,
		REG_BASE_BLUE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic degen;
		logic nzneg;
	} flags_t;

	localparam int NORM_MSB = 30;
	localparam int ROOT_STAGES = 32;
	localparam int DIV_STAGES = 15;
	localparam int ROOT_DIV_LAT = ROOT_STAGES + DIV_STAGES;
	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [7:0] SHADE_MAX = 8'd255;
	localparam logic [7:0] BASE_RESET = 8'd255;

endpackage

/* design/tnsc_root_div.sv */
// Pipelined integer square root of the squared length and normal z divide.
module tnsc_root_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] sq_sum,
	input  logic [30:0] mz,
	output logic [14:0] quo
);

	localparam int Rs = tnsc_pkg::ROOT_STAGES;
	localparam int Ds = tnsc_pkg::DIV_STAGES;

	logic [63:0] rx_s  [0:Rs];
	logic [63:0] rr_s  [0:Rs];
	logic [30:0] rmz_s [0:Rs];
	logic [44:0] drm_s [0:Ds];
	logic [31:0] dden_s[0:Ds];
	logic [14:0] dq_s  [0:Ds];

	assign rx_s[0]  = sq_sum;
	assign rr_s[0]  = 64'd0;
	assign rmz_s[0] = mz;

	assign drm_s[0]  = {rmz_s[Rs], 14'd0};
	assign dden_s[0] = rr_s[Rs][31:0];
	assign dq_s[0]   = 15'd0;

	// one result bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= Rs; k++) begin
				logic [63:0] bt;
				logic [63:0] t;
				bt = 64'd1 << (62 - 2 * (k - 1));
				t = rr_s[k-1] + bt;
				if (rx_s[k-1] >= t) begin
					rx_s[k] <= rx_s[k-1] - t;
					rr_s[k] <= (rr_s[k-1] >> 1) + bt;
				end else begin
					rx_s[k] <= rx_s[k-1];
					rr_s[k] <= rr_s[k-1] >> 1;
				end
				rmz_s[k] <= rmz_s[k-1];
			end
			for (int i = 1; i <= Ds; i++) begin
				logic [46:0] sd;
				sd = 47'(dden_s[i-1]) << (Ds - i);
				if (47'(drm_s[i-1]) >= sd) begin
					drm_s[i] <= 45'(47'(drm_s[i-1]) - sd);
					dq_s[i] <= dq_s[i-1] | (15'd1 << (Ds - i));
				end else begin
					drm_s[i] <= drm_s[i-1];
					dq_s[i] <= dq_s[i-1];
				end
				dden_s[i] <= dden_s[i-1];
			end
		end
	end

	assign quo = dq_s[Ds];

endmodule

/* design/triangle_normal_shade_cull_core.sv */
// Top level of the triangle flat shade and back-face cull core.
//
// Input words on s_t* carry one triangle (nine signed coordinates); each
// accepted word gives exactly one output word on m_t* with the shaded color,
// unit normal z, mean depth and the cull flag in m_tuser.
// Base color registers are written on the cfg_* port (index 0 red, 1 green,
// 2 blue, others ignored); cfg_ready is always high. Write them while idle.
// The pipeline has edge, cross product, normalize and square stages,
// then 32 square root stages (one root bit each), 15 divide stages (one
// quotient bit each) and one shade stage.
// Throughput is one word per cycle while the output is not stalled.
// The whole pipeline advances together: it holds when the output word is
// valid and m_tready is low, and s_tready drops for that time.
// Reset empties the pipeline and sets the base color to 255 on each channel.
`include "assert_macros.svh"
module triangle_normal_shade_cull_core #(
	parameter int COORD_WIDTH = 16,
	localparam int InDw = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [7:0]      cfg_data,
	input  logic            s_tvalid,
	output logic            s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
	input  logic [InDw-1:0] s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// shade_red, shade_green, shade_blue, mean_depth, unit_normal_z
	output logic [55:0]     m_tdata,
	// culled
	output logic [0:0]      m_tuser
);

	localparam int W = COORD_WIDTH;
	localparam int EdgeShift = (W > 16) ? W - 16 : 0;
	localparam int MagW = W + 1;
	localparam int QS = 7 + tnsc_pkg::ROOT_DIV_LAT;
	localparam int Nst = QS + 1;
	// ceil(2^(W+2) / 3): exact divide by 3 for magnitudes below 2^(W+1)
	localparam longint Div3Recip = ((longint'(1) << (W + 2)) + 2) / 3;

	logic en;
	logic [7:0] base_q [0:2];
	logic vld_s [1:Nst];

	logic signed [16:0] e_s1 [0:5];
	logic signed [W+1:0] zsum_s1;
	logic signed [33:0] prod_s2 [0:5];
	logic signed [34:0] n_s3 [0:2];
	logic [32:0] mag_s4 [0:2];
	logic [4:0] lsh_s4;
	logic [1:0] rsh_s4;
	logic [30:0] sc_s5 [0:2];
	logic [61:0] sq_s6 [0:2];
	logic [30:0] mz_s6;
	logic [63:0] sum_s7;
	logic [30:0] mz_s7;
	logic [14:0] q_rd;

	tnsc_pkg::flags_t fl_s [4:QS];
	logic dsg_s [2:QS];
	logic [MagW-1:0] dq_s [2:QS];

	logic culled_s55;
	logic [7:0] shade_s55 [0:2];
	logic [15:0] depth_s55;
	logic [15:0] unz_s55;

	logic signed [W-1:0] crd [0:8];
	logic [32:0] mag_c [0:2];
	logic [32:0] mor_c;
	logic [5:0] pos_c;

	function automatic logic signed [16:0] calc_edge(input logic signed [W-1:0] p,
		input logic signed [W-1:0] q);
		logic signed [W:0] d;
		logic [W:0] m;
		logic [W:0] ms;
		d = (W+1)'(p) - (W+1)'(q);
		m = d[W] ? (W+1)'(-d) : (W+1)'(d);
		ms = m >> EdgeShift;
		return d[W] ? -17'(ms) : 17'(ms);
	endfunction

	assign en = !vld_s[Nst] || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q[0] <= tnsc_pkg::BASE_RESET;
			base_q[1] <= tnsc_pkg::BASE_RESET;
			base_q[2] <= tnsc_pkg::BASE_RESET;
		end else if (cfg_valid) begin
			case (tnsc_pkg::reg_idx_t'(cfg_index))
				tnsc_pkg::REG_BASE_RED:   base_q[0] <= cfg_data;
				tnsc_pkg::REG_BASE_GREEN: base_q[1] <= cfg_data;
				tnsc_pkg::REG_BASE_BLUE:  base_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= Nst; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int j = 2; j <= Nst; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) crd[i] = s_tdata[i*W +: W];
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = n_s3[i][34] ? 33'(-n_s3[i]) : 33'(n_s3[i]);
		end
		mor_c = mag_c[0] | mag_c[1] | mag_c[2];
		pos_c = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (mor_c[i]) pos_c = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// edges b-a and c-a, depth sum
			e_s1[0] <= calc_edge(crd[3], crd[0]);
			e_s1[1] <= calc_edge(crd[4], crd[1]);
			e_s1[2] <= calc_edge(crd[5], crd[2]);
			e_s1[3] <= calc_edge(crd[6], crd[0]);
			e_s1[4] <= calc_edge(crd[7], crd[1]);
			e_s1[5] <= calc_edge(crd[8], crd[2]);
			zsum_s1 <= (W+2)'(crd[2]) + (W+2)'(crd[5]) + (W+2)'(crd[8]);

			prod_s2[0] <= e_s1[1] * e_s1[5];
			prod_s2[1] <= e_s1[2] * e_s1[4];
			prod_s2[2] <= e_s1[2] * e_s1[3];
			prod_s2[3] <= e_s1[0] * e_s1[5];
			prod_s2[4] <= e_s1[0] * e_s1[4];
			prod_s2[5] <= e_s1[1] * e_s1[3];
			dsg_s[2] <= zsum_s1[W+1];
			dq_s[2] <= zsum_s1[W+1] ? MagW'(-zsum_s1) : MagW'(zsum_s1);

			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= 35'(prod_s2[2*i]) - 35'(prod_s2[2*i+1]);
			end

			for (int i = 0; i < 3; i++) mag_s4[i] <= mag_c[i];
			fl_s[4].degen <= (mor_c == 33'd0);
			fl_s[4].nzneg <= n_s3[2][34];
			if (pos_c > 6'(tnsc_pkg::NORM_MSB)) begin
				lsh_s4 <= 5'd0;
				rsh_s4 <= 2'(pos_c - 6'(tnsc_pkg::NORM_MSB));
			end else begin
				lsh_s4 <= 5'(6'(tnsc_pkg::NORM_MSB) - pos_c);
				rsh_s4 <= 2'd0;
			end

			for (int i = 0; i < 3; i++) begin
				sc_s5[i] <= 31'((63'(mag_s4[i]) << lsh_s4) >> rsh_s4);
			end

			for (int i = 0; i < 3; i++) sq_s6[i] <= 62'(sc_s5[i]) * 62'(sc_s5[i]);
			mz_s6 <= sc_s5[2];

			sum_s7 <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
			mz_s7 <= mz_s6;

			for (int j = 5; j <= QS; j++) fl_s[j] <= fl_s[j-1];

			// depth magnitude divided by 3 with a reciprocal multiply
			for (int j = 3; j <= QS; j++) dsg_s[j] <= dsg_s[j-1];
			dq_s[3] <= MagW'(((2*MagW)'(dq_s[2]) * (2*MagW)'(Div3Recip)) >> (W + 2));
			for (int j = 4; j <= QS; j++) dq_s[j] <= dq_s[j-1];

			begin
				logic [14:0] q;
				logic [14:0] inten;
				logic signed [MagW:0] dv;
				q = (q_rd > tnsc_pkg::ONE_Q14) ? tnsc_pkg::ONE_Q14 : q_rd;
				if (fl_s[QS].degen) q = 15'd0;
				inten = (fl_s[QS].nzneg || fl_s[QS].degen) ? 15'd0 : q;
				unz_s55 <= fl_s[QS].nzneg ? -16'(q) : 16'(q);
				culled_s55 <= fl_s[QS].degen || fl_s[QS].nzneg;
				for (int i = 0; i < 3; i++) begin
					logic [22:0] pr;
					pr = 23'(base_q[i]) * 23'(inten);
					shade_s55[i] <= (pr[22:14] > 9'(tnsc_pkg::SHADE_MAX)) ?
						tnsc_pkg::SHADE_MAX : pr[21:14];
				end
				dv = dsg_s[QS] ? -(MagW+1)'(dq_s[QS]) : (MagW+1)'(dq_s[QS]);
				depth_s55 <= 16'(dv);
			end
		end
	end

	tnsc_root_div u_root_div (
		.clk    (clk),
		.en     (en),
		.sq_sum (sum_s7),
		.mz     (mz_s7),
		.quo    (q_rd)
	);

	assign m_tvalid = vld_s[Nst];
	assign m_tuser = culled_s55;
	assign m_tdata = {unz_s55, depth_s55, shade_s55[2], shade_s55[1], shade_s55[0]};

	`CHK_IMP(a_cull_dark, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[23:0] == 24'd0,
		"culled word carries color")
	`CHK_IMP(a_unz_range, clk, arst_n, m_tvalid,
		($signed(m_tdata[55:40]) <= 16'sd16384) && ($signed(m_tdata[55:40]) >= -16'sd16384),
		"unit normal z out of range")
	`CHK_CLK(a_stall_hold, clk, arst_n, !en |=> $stable(m_tdata) && m_tvalid,
		"output moved during stall")

endmodule

/* dv/triangle_normal_shade_cull_checker.sv */
// Checker for the triangle shade and cull core: predicts and compares output words.
`timescale 1ns / 1ps
module triangle_normal_shade_cull_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [143:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [0:0]  m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        culled;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] depth;
		logic [15:0] nz;
	} shade_word_t;

	logic [7:0] color_r, color_g, color_b;
	shade_word_t shade_q[$];

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] scale_chan(input logic [7:0] b, input logic [63:0] i);
		logic [63:0] v;
		v = (64'(b) * i) >> 14;
		return v > 255 ? tnsc_pkg::SHADE_MAX : v[7:0];
	endfunction

	function automatic shade_word_t shade_triangle(input logic [143:0] d);
		longint c[9];
		longint ux, uy, uz, wx, wy, wz, nx, ny, nz, depth, unz;
		logic [63:0] mx, my, mz, mmax, len, q, inten;
		shade_word_t r;
		for (int i = 0; i < 9; i++) c[i] = longint'($signed(d[i*16 +: 16]));
		ux = c[3] - c[0]; uy = c[4] - c[1]; uz = c[5] - c[2];
		wx = c[6] - c[0]; wy = c[7] - c[1]; wz = c[8] - c[2];
		nx = uy * wz - uz * wy;
		ny = uz * wx - ux * wz;
		nz = ux * wy - uy * wx;
		mx = nx < 0 ? -nx : nx;
		my = ny < 0 ? -ny : ny;
		mz = nz < 0 ? -nz : nz;
		mmax = mx;
		if (my > mmax) mmax = my;
		if (mz > mmax) mmax = mz;
		unz = 0;
		inten = 0;
		if (mmax != 0) begin
			while (mmax >= (64'd1 << 31)) begin
				mmax >>= 1; mx >>= 1; my >>= 1; mz >>= 1;
			end
			while (mmax < (64'd1 << 30)) begin
				mmax <<= 1; mx <<= 1; my <<= 1; mz <<= 1;
			end
			len = root64(mx * mx + my * my + mz * mz);
			q = len != 0 ? (mz * 16384) / len : 0;
			if (q > 16384) q = 16384;
			unz = nz < 0 ? -longint'(q) : longint'(q);
			inten = nz > 0 ? q : 0;
		end
		depth = (c[2] + c[5] + c[8]) / 3;
		r.culled = (mmax == 0) || (nz < 0);
		r.red = scale_chan(color_r, inten);
		r.green = scale_chan(color_g, inten);
		r.blue = scale_chan(color_b, inten);
		r.depth = depth[15:0];
		r.nz = unz[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shade_word_t e, a;
		if (!arst_n) begin
			color_r <= tnsc_pkg::BASE_RESET;
			color_g <= tnsc_pkg::BASE_RESET;
			color_b <= tnsc_pkg::BASE_RESET;
			fail_count <= 0;
			pending <= 0;
			shade_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tnsc_pkg::REG_BASE_RED:   color_r <= cfg_data;
					tnsc_pkg::REG_BASE_GREEN: color_g <= cfg_data;
					tnsc_pkg::REG_BASE_BLUE:  color_b <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) shade_q.insert(shade_q.size(), shade_triangle(s_tdata));
			if (m_tvalid && m_tready) begin
				a = {m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
					m_tdata[39:24], m_tdata[55:40]};
				if (shade_q.size() == 0) begin
					$display("%0t: unexpected word, actual %h", $time, a);
					fail_count <= fail_count + 1;
				end else begin
					e = shade_q.pop_front();
					if (e !== a) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, a);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= shade_q.size();
		end
	end

endmodule

/* dv/triangle_normal_shade_cull_core_tb.sv */
// Testbench top for the triangle shade and cull core: stimulus and verdict.
`timescale 1ns / 1ps
module triangle_normal_shade_cull_core_tb;

	localparam int LAT = 55;
	localparam int STALL_LIMIT = 2000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic s_tvalid, s_tready;
	logic [143:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [55:0] m_tdata;
	logic [0:0] m_tuser;
	int fail_count, pending;
	int quiet;
	bit calm;

	triangle_normal_shade_cull_core dut (.*);

	triangle_normal_shade_cull_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sink stalls in bursts
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
			|| pending == 0)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_color(input tnsc_pkg::reg_idx_t idx, input logic [7:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_triangle(input logic [143:0] d);
		int n;
		if (!calm && $urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 14);
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	function automatic logic [143:0] tri_pack(input logic [15:0] c[9]);
		logic [143:0] d;
		for (int i = 0; i < 9; i++) d[i*16 +: 16] = c[i];
		return d;
	endfunction

	function automatic logic [15:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [143:0] rnd_triangle();
		logic [15:0] c[9];
		int k;
		for (int i = 0; i < 9; i++) c[i] = rnd_coord();
		k = $urandom_range(0, 9);
		if (k == 0) begin
			for (int i = 3; i < 9; i++) c[i] = c[i % 3];
		end else if (k == 1) begin
			for (int i = 0; i < 3; i++) c[6 + i] = 16'(2 * $signed(c[3 + i]) - $signed(c[i]));
		end else if (k == 2) begin
			c[2] = 16'h7FFF; c[5] = 16'h7FFF; c[8] = 16'h7FFF;
		end
		return tri_pack(c);
	endfunction

	initial begin
		logic [15:0] c[9];
		logic [7:0] colors[4][3];
		colors = '{'{255, 255, 255}, '{0, 0, 0}, '{128, 1, 254}, '{255, 0, 77}};
		calm = 0;
		arst_n = 0;
		cfg_valid = 0; cfg_index = tnsc_pkg::REG_BASE_RED; cfg_data = 0;
		s_tvalid = 0; s_tdata = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: front face, back face, degenerate, extremes
		c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};       send_triangle(tri_pack(c));
		c = '{0, 0, 0, 0, 256, 0, 256, 0, 0};       send_triangle(tri_pack(c));
		c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};           send_triangle(tri_pack(c));
		c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};           send_triangle(tri_pack(c));
		c = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h7FFF};          send_triangle(tri_pack(c));
		c = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'h7FFF};          send_triangle(tri_pack(c));
		// tiny positive and negative z on a steep face
		c = '{0, 0, 0, 16'h7FFF, 0, 16'h7FFF, 0, 1, 16'h7FFF}; send_triangle(tri_pack(c));
		c = '{0, 0, 0, 16'h7FFF, 1, 16'h7FFF, 16'h7FFF, 0, 16'h7FFF}; send_triangle(tri_pack(c));
		c = '{0, 0, 16'hFFFF, 256, 0, 16'hFFFF, 0, 256, 16'hFFFF}; send_triangle(tri_pack(c));
		c = '{0, 0, 16'h8000, 256, 0, 16'h8000, 0, 256, 16'h8000}; send_triangle(tri_pack(c));
		drain();

		for (int p = 0; p < 4; p++) begin
			write_color(tnsc_pkg::REG_BASE_RED, colors[p][0]);
			write_color(tnsc_pkg::REG_BASE_GREEN, colors[p][1]);
			write_color(tnsc_pkg::REG_BASE_BLUE, colors[p][2]);
			cfg_valid <= 1; cfg_index <= 2'd3; cfg_data <= 8'hAA;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 0;
			for (int i = 0; i < 150; i++) begin
				if (p == 3 && i == 100) calm = 1;
				send_triangle(rnd_triangle());
			end
			drain();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/tnsc_pkg.sv
design/tnsc_root_div.sv
design/triangle_normal_shade_cull_core.sv
dv/triangle_normal_shade_cull_checker.sv
dv/triangle_normal_shade_cull_core_tb.sv
